// ===== rtl/q2e_pkg.sv =====
package q2e_pkg;

    // default build parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int QUAT_WIDTH_DEF    = 16;

    // internal formats
    localparam int Q_W    = 16;   // aligned Q1.15 component
    localparam int P_W    = 32;   // Q2.30 product
    localparam int T_W    = 34;   // sum of products, doubled
    localparam int S_W    = 31;   // clamped asin argument, within +-2^29
    localparam int SQ_W   = 61;   // radicand and root work width
    localparam int C_W    = 30;   // square root, at most 2^29
    localparam int V_W    = 37;   // cordic vector component
    localparam int Z_W    = 29;   // cordic angle, Q.24 radians
    localparam int A_W    = 16;   // angle in Q3.12
    localparam int M_W    = 12;   // gimbal margin register
    localparam int LANES  = 4;    // pitch, yaw, roll, locked yaw
    localparam int ROOT_STEPS = 30;

    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW   = 1;
    localparam int LANE_ROLL  = 2;
    localparam int LANE_ALT   = 3;

    localparam int ATAN_LEN = 24;
    localparam logic [23:0] ATAN_TABLE [ATAN_LEN] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    localparam logic signed [Z_W-1:0] PI_Q24      = Z_W'(52707179);
    localparam logic signed [A_W-1:0] PI_Q12      = A_W'(12868);
    localparam logic signed [A_W-1:0] HALF_PI_Q12 = A_W'(6434);
    localparam logic signed [S_W-1:0] ONE_Q29     = S_W'(536870912);
    localparam logic [SQ_W-1:0]       ONE_Q58     = SQ_W'(1) << 58;

    typedef struct packed {
        logic pos;
        logic neg;
    } sat_t;

    typedef struct packed {
        logic signed [S_W-1:0] s;
        sat_t                  sat;
        logic signed [T_W-1:0] yaw_num;
        logic signed [T_W-1:0] yaw_den;
        logic signed [T_W-1:0] roll_num;
        logic signed [T_W-1:0] roll_den;
        logic signed [T_W-1:0] alt_num;
        logic signed [T_W-1:0] alt_den;
    } terms_t;

    typedef struct packed {
        logic                  zero;
        logic signed [V_W-1:0] x;
        logic signed [V_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } vec_t;

    // quadrant fold ahead of the cordic row; zero numerator keeps a fixed angle
    function automatic vec_t cordic_prep(input logic signed [V_W-1:0] y,
                                         input logic signed [V_W-1:0] x);
        vec_t r;
        r.zero = (y == '0);
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        if (x < 0) begin
            if (r.zero) begin
                r.z = PI_Q24;
            end
            else begin
                r.z = (y > 0) ? PI_Q24 : -PI_Q24;
                r.x = -x;
                r.y = -y;
            end
        end
        return r;
    endfunction

    // Q.24 to Q3.12, round half away from zero, then clamp
    function automatic logic signed [A_W-1:0] to_q12(input logic signed [Z_W-1:0] z,
                                                     input logic signed [A_W-1:0] lim);
        logic [Z_W-1:0]    mag;
        logic [Z_W-13:0]   r;
        logic [A_W-1:0]    m;
        mag = (z < 0) ? Z_W'(-z) : Z_W'(z);
        r   = (Z_W-12)'((mag + Z_W'(2048)) >> 12);
        m   = (r > (Z_W-12)'(lim)) ? A_W'(lim) : A_W'(r);
        return (z < 0) ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== rtl/q2e_root_cell.sv =====
module q2e_root_cell
    import q2e_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  logic [SQ_W-1:0] up_rem,
    input  logic [SQ_W-1:0] up_root,
    input  terms_t          up_terms,
    output logic            dn_valid,
    input  logic            dn_ready,
    output logic [SQ_W-1:0] dn_rem,
    output logic [SQ_W-1:0] dn_root,
    output terms_t          dn_terms
);

    // one result bit per cell, trial bit 4^(ROOT_STEPS-1-STEP)
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - STEP));

    logic            valid_reg;
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] root_reg, root_next;
    terms_t          terms_reg;
    logic [SQ_W-1:0] trial;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        trial = up_root + BIT;
        if (up_rem >= trial)
        begin
            rem_next  = up_rem - trial;
            root_next = (up_root >> 1) + BIT;
        end
        else
        begin
            rem_next  = up_rem;
            root_next = up_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            terms_reg <= up_terms;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_root  = root_reg;
    assign dn_terms = terms_reg;

endmodule

// ===== rtl/q2e_cordic_cell.sv =====
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  vec_t [LANES-1:0] up_vec,
    input  sat_t             up_sat,
    output logic             dn_valid,
    input  logic             dn_ready,
    output vec_t [LANES-1:0] dn_vec,
    output sat_t             dn_sat
);

    localparam logic signed [Z_W-1:0] ANGLE = Z_W'(ATAN_TABLE[STEP]);

    logic             valid_reg;
    vec_t [LANES-1:0] vec_reg, vec_next;
    sat_t             sat_reg;

    assign up_ready = !valid_reg || dn_ready;

    // one vectoring micro-rotation on every lane not flagged zero
    always_comb
    begin
        vec_next = up_vec;
        for (int i = 0; i < LANES; i++)
        begin
            if (!up_vec[i].zero)
            begin
                if (up_vec[i].y > 0)
                begin
                    vec_next[i].x = up_vec[i].x + (up_vec[i].y >>> STEP);
                    vec_next[i].y = up_vec[i].y - (up_vec[i].x >>> STEP);
                    vec_next[i].z = up_vec[i].z + ANGLE;
                end
                else
                begin
                    vec_next[i].x = up_vec[i].x - (up_vec[i].y >>> STEP);
                    vec_next[i].y = up_vec[i].y + (up_vec[i].x >>> STEP);
                    vec_next[i].z = up_vec[i].z - ANGLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            vec_reg <= vec_next;
            sat_reg <= up_sat;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_vec   = vec_reg;
    assign dn_sat   = sat_reg;

endmodule

// ===== rtl/quaternion_to_euler_angles_unit.sv =====
// Quaternion (x, y, z, w, signed Q1.(QUAT_WIDTH-1)) to ZYX Euler angles in Q3.12
// radians with a gimbal-lock flag. One item enters per cycle when the output side
// keeps up; each item passes through three registers for products, sums and the
// radicand, thirty square root cells (one root bit each) for cos(pitch), one
// quadrant fold, one cordic cell per stage running the pitch, yaw, roll and
// locked-yaw vectors side by side, a rounding register, then the gimbal-lock
// select in the output register. Every stage holds its item until the next one
// frees up, so a stalled output only backs up the chain as far as it is full.
// gimbal_margin can be written at any time through cfg_valid; it is read by the
// last stage and should only change while no item is in flight.
module quaternion_to_euler_angles_unit
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int QUAT_WIDTH    = QUAT_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [M_W-1:0]               gimbal_margin,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [14:0]           roll_angle,
    output logic signed [13:0]           pitch_angle,
    output logic signed [15:0]           yaw_angle,
    output logic                         gimbal_lock
);

    // ---------------- configuration register
    logic [M_W-1:0] margin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= M_W'(1);
        end
        else if (cfg_valid)
        begin
            margin_reg <= gimbal_margin;
        end
    end

    // ---------------- input alignment to Q1.15 (floor when wider)
    logic signed [QUAT_WIDTH-1:0] raw [4];
    logic signed [Q_W-1:0]        q15 [4];

    assign raw[0] = quat_x;
    assign raw[1] = quat_y;
    assign raw[2] = quat_z;
    assign raw[3] = quat_w;

    generate
        for (genvar g = 0; g < 4; g++)
        begin : g_align
            if (QUAT_WIDTH >= Q_W)
            begin : g_wide
                assign q15[g] = raw[g][QUAT_WIDTH-1 -: Q_W];
            end
            else
            begin : g_narrow
                assign q15[g] = {raw[g], {(Q_W-QUAT_WIDTH){1'b0}}};
            end
        end
    endgenerate

    // ---------------- stage 1: the ten Q2.30 products
    logic                  s1_valid_reg, s1_ready;
    logic signed [P_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [P_W-1:0] wy_reg, xz_reg, xy_reg, wz_reg, wx_reg, yz_reg;
    logic                  s2_ready;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            xx_reg <= P_W'(q15[0] * q15[0]);
            yy_reg <= P_W'(q15[1] * q15[1]);
            zz_reg <= P_W'(q15[2] * q15[2]);
            ww_reg <= P_W'(q15[3] * q15[3]);
            wy_reg <= P_W'(q15[3] * q15[1]);
            xz_reg <= P_W'(q15[0] * q15[2]);
            xy_reg <= P_W'(q15[0] * q15[1]);
            wz_reg <= P_W'(q15[3] * q15[2]);
            wx_reg <= P_W'(q15[3] * q15[0]);
            yz_reg <= P_W'(q15[1] * q15[2]);
        end
    end

    // ---------------- stage 2: atan2 terms and the clamped asin argument
    logic                  s2_valid_reg, s3_ready;
    terms_t                s2_terms_reg, s2_terms_next;
    logic signed [T_W-1:0] s_full;

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_comb
    begin
        s_full = T_W'(wy_reg) - T_W'(xz_reg);
        s2_terms_next.sat.pos = (s_full >= T_W'(ONE_Q29));
        s2_terms_next.sat.neg = (s_full <= -T_W'(ONE_Q29));
        if (s2_terms_next.sat.pos)
        begin
            s2_terms_next.s = ONE_Q29;
        end
        else if (s2_terms_next.sat.neg)
        begin
            s2_terms_next.s = -ONE_Q29;
        end
        else
        begin
            s2_terms_next.s = S_W'(s_full);
        end
        s2_terms_next.yaw_num  = (T_W'(xy_reg) + T_W'(wz_reg)) <<< 1;
        s2_terms_next.yaw_den  = T_W'(xx_reg) - T_W'(yy_reg) - T_W'(zz_reg) + T_W'(ww_reg);
        s2_terms_next.roll_num = (T_W'(wx_reg) + T_W'(yz_reg)) <<< 1;
        s2_terms_next.roll_den = T_W'(ww_reg) - T_W'(xx_reg) - T_W'(yy_reg) + T_W'(zz_reg);
        s2_terms_next.alt_num  = (T_W'(yz_reg) - T_W'(wx_reg)) <<< 1;
        s2_terms_next.alt_den  = (T_W'(xz_reg) + T_W'(wy_reg)) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_terms_reg <= s2_terms_next;
        end
    end

    // ---------------- stage 3: radicand 1 - s^2 in Q.58
    logic                  s3_valid_reg;
    terms_t                s3_terms_reg;
    logic [SQ_W-1:0]       rad_reg;
    logic signed [61:0]    s_sq;
    logic                  root_ready [ROOT_STEPS+1];
    logic                  root_valid [ROOT_STEPS+1];
    logic [SQ_W-1:0]       root_rem   [ROOT_STEPS+1];
    logic [SQ_W-1:0]       root_val   [ROOT_STEPS+1];
    terms_t                root_terms [ROOT_STEPS+1];

    assign s_sq     = s2_terms_reg.s * s2_terms_reg.s;
    assign s3_ready = !s3_valid_reg || root_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            rad_reg      <= ONE_Q58 - SQ_W'(s_sq);
            s3_terms_reg <= s2_terms_reg;
        end
    end

    // ---------------- square root cells
    assign root_valid[0] = s3_valid_reg;
    assign root_rem[0]   = rad_reg;
    assign root_val[0]   = '0;
    assign root_terms[0] = s3_terms_reg;

    generate
        for (genvar k = 0; k < ROOT_STEPS; k++)
        begin : g_root
            q2e_root_cell #(
                .STEP (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (root_valid[k]),
                .up_ready (root_ready[k]),
                .up_rem   (root_rem[k]),
                .up_root  (root_val[k]),
                .up_terms (root_terms[k]),
                .dn_valid (root_valid[k+1]),
                .dn_ready (root_ready[k+1]),
                .dn_rem   (root_rem[k+1]),
                .dn_root  (root_val[k+1]),
                .dn_terms (root_terms[k+1])
            );
        end
    endgenerate

    // ---------------- quadrant fold ahead of the cordic row
    logic             prep_valid_reg;
    vec_t [LANES-1:0] prep_vec_reg, prep_vec_next;
    sat_t             prep_sat_reg;
    logic             cor_ready [CORDIC_STAGES+1];
    logic             cor_valid [CORDIC_STAGES+1];
    vec_t [LANES-1:0] cor_vec   [CORDIC_STAGES+1];
    sat_t             cor_sat   [CORDIC_STAGES+1];
    terms_t           last_terms;
    logic [C_W-1:0]   cos_pitch;

    assign last_terms      = root_terms[ROOT_STEPS];
    assign cos_pitch       = root_val[ROOT_STEPS][C_W-1:0];
    assign root_ready[ROOT_STEPS] = !prep_valid_reg || cor_ready[0];

    always_comb
    begin
        prep_vec_next[LANE_PITCH] = cordic_prep(V_W'(last_terms.s),
                                                $signed(V_W'(cos_pitch)));
        prep_vec_next[LANE_YAW]   = cordic_prep(V_W'(last_terms.yaw_num),
                                                V_W'(last_terms.yaw_den));
        prep_vec_next[LANE_ROLL]  = cordic_prep(V_W'(last_terms.roll_num),
                                                V_W'(last_terms.roll_den));
        prep_vec_next[LANE_ALT]   = cordic_prep(V_W'(last_terms.alt_num),
                                                V_W'(last_terms.alt_den));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (root_ready[ROOT_STEPS])
        begin
            prep_valid_reg <= root_valid[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_ready[ROOT_STEPS] && root_valid[ROOT_STEPS])
        begin
            prep_vec_reg <= prep_vec_next;
            prep_sat_reg <= last_terms.sat;
        end
    end

    // ---------------- cordic cells, all four vectors in lockstep
    assign cor_valid[0] = prep_valid_reg;
    assign cor_vec[0]   = prep_vec_reg;
    assign cor_sat[0]   = prep_sat_reg;

    generate
        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_cordic
            q2e_cordic_cell #(
                .STEP (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (cor_valid[k]),
                .up_ready (cor_ready[k]),
                .up_vec   (cor_vec[k]),
                .up_sat   (cor_sat[k]),
                .dn_valid (cor_valid[k+1]),
                .dn_ready (cor_ready[k+1]),
                .dn_vec   (cor_vec[k+1]),
                .dn_sat   (cor_sat[k+1])
            );
        end
    endgenerate

    // ---------------- rounding to Q3.12 and clamping
    logic                  rnd_valid_reg, rnd_ready;
    logic signed [A_W-1:0] pitch_reg, yaw_reg, roll_reg, alt_reg;
    logic signed [A_W-1:0] pitch_next;
    vec_t [LANES-1:0]      cor_last;
    logic                  out_step;

    assign cor_last                = cor_vec[CORDIC_STAGES];
    assign rnd_ready               = !rnd_valid_reg || out_step;
    assign cor_ready[CORDIC_STAGES] = rnd_ready;

    // saturated asin argument pins pitch exactly at the pole
    always_comb
    begin
        if (cor_sat[CORDIC_STAGES].pos)
        begin
            pitch_next = HALF_PI_Q12;
        end
        else if (cor_sat[CORDIC_STAGES].neg)
        begin
            pitch_next = -HALF_PI_Q12;
        end
        else
        begin
            pitch_next = to_q12(cor_last[LANE_PITCH].z, HALF_PI_Q12);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else if (rnd_ready)
        begin
            rnd_valid_reg <= cor_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rnd_ready && cor_valid[CORDIC_STAGES])
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= to_q12(cor_last[LANE_YAW].z, PI_Q12);
            roll_reg  <= to_q12(cor_last[LANE_ROLL].z, PI_Q12);
            alt_reg   <= to_q12(cor_last[LANE_ALT].z, PI_Q12);
        end
    end

    // ---------------- gimbal-lock select, output register
    logic                  out_valid_reg;
    logic signed [A_W-1:0] pitch_abs;
    logic [A_W-1:0]        pole_dist;
    logic                  lock_next;
    logic signed [A_W-1:0] yaw_next, roll_next;
    logic signed [14:0]    roll_out_reg;
    logic signed [13:0]    pitch_out_reg;
    logic signed [15:0]    yaw_out_reg;
    logic                  lock_out_reg;

    assign out_step = !out_valid_reg || out_ready;

    always_comb
    begin
        pitch_abs = (pitch_reg < 0) ? -pitch_reg : pitch_reg;
        pole_dist = A_W'(HALF_PI_Q12 - pitch_abs);
        lock_next = (pole_dist < A_W'(margin_reg));
        if (lock_next)
        begin
            roll_next = '0;
            // near the negative pole the locked yaw folds to pi - yaw
            yaw_next  = (pitch_reg < 0) ? (PI_Q12 - alt_reg) : alt_reg;
        end
        else
        begin
            roll_next = roll_reg;
            yaw_next  = yaw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_step)
        begin
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_step && rnd_valid_reg)
        begin
            roll_out_reg  <= roll_next[14:0];
            pitch_out_reg <= pitch_reg[13:0];
            yaw_out_reg   <= yaw_next;
            lock_out_reg  <= lock_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_out_reg;
    assign pitch_angle = pitch_out_reg;
    assign yaw_angle   = yaw_out_reg;
    assign gimbal_lock = lock_out_reg;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import q2e_pkg::*;

    // angle and scale constants, kept as plain integers for the predictor
    localparam longint PI_Q24_L   = 52707179;
    localparam longint PI_Q12_L   = 12868;
    localparam longint HALF_PI_L  = 6434;
    localparam longint ONE_Q29_L  = 536870912;
    localparam int     STAGES     = 16;
    localparam int     DRAIN      = 80;      // longer than the pipeline is deep
    localparam int     LIMIT      = 400000;

    typedef struct {
        logic signed [14:0] roll;
        logic signed [13:0] pitch;
        logic signed [15:0] yaw;
        logic               lock;
    } euler_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [M_W-1:0] gimbal_margin = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic signed [15:0] quat_w = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [14:0] roll_angle;
    logic signed [13:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic gimbal_lock;

    euler_t euler_q[$];          // predicted angles, oldest first
    logic [M_W-1:0] margin_now = 12'd1;
    int cycle = 0;
    int mismatches = 0;

    // stretches without any idling on either side
    wire quiet = (cycle % 3000) < 600;

    always #10 clk = ~clk;

    quaternion_to_euler_angles_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .gimbal_margin(gimbal_margin),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .gimbal_lock(gimbal_lock)
    );

    // integer square root, floor
    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring cordic atan2(yv, xv), q.24 radians
    function automatic longint vec_angle(longint yv, longint xv);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (yv == 0) return (xv < 0) ? PI_Q24_L : 0;
        if (xv < 0) begin
            ang = (yv > 0) ? PI_Q24_L : -PI_Q24_L;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv += dx;
                yv -= dy;
                ang += longint'(ATAN_TABLE[i]);
            end
            else begin
                xv -= dx;
                yv += dy;
                ang -= longint'(ATAN_TABLE[i]);
            end
        end
        return ang;
    endfunction

    // q.24 to q3.12, half away from zero, then clamp
    function automatic longint round_q12(longint a, longint lim);
        longint r;
        r = (a >= 0) ? ((a + 2048) >>> 12) : -((-a + 2048) >>> 12);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t zyx_angles(longint x, longint y, longint z, longint w,
                                          longint margin);
        euler_t e;
        longint s;
        longint c;
        longint pitch;
        longint yaw;
        longint roll;
        longint pole_gap;
        logic lock;
        s = w * y - x * z;
        if (s > ONE_Q29_L) s = ONE_Q29_L;
        if (s < -ONE_Q29_L) s = -ONE_Q29_L;
        c = root_floor(longint'((64'sd1 << 58) - s * s));
        if (s == ONE_Q29_L) pitch = HALF_PI_L;
        else if (s == -ONE_Q29_L) pitch = -HALF_PI_L;
        else pitch = round_q12(vec_angle(s, c), HALF_PI_L);
        pole_gap = HALF_PI_L - ((pitch < 0) ? -pitch : pitch);
        lock = pole_gap < margin;
        if (!lock) begin
            yaw = round_q12(vec_angle(2 * (x * y + w * z), x*x - y*y - z*z + w*w), PI_Q12_L);
            roll = round_q12(vec_angle(2 * (w * x + y * z), w*w - x*x - y*y + z*z),
                             PI_Q12_L);
        end
        else begin
            yaw = round_q12(vec_angle(2 * (y * z - x * w), 2 * (x * z + y * w)), PI_Q12_L);
            roll = 0;
            // negative pitch folds yaw about pi
            if (pitch < 0) yaw = PI_Q12_L - yaw;
        end
        e.roll = roll[14:0];
        e.pitch = pitch[13:0];
        e.yaw = yaw[15:0];
        e.lock = lock;
        return e;
    endfunction

    // input side: present one quaternion, hold until accepted, then maybe idle
    task automatic send_quat(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic signed [15:0] w);
        in_valid <= 1'b1;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        quat_w <= w;
        do @(posedge clk); while (!in_ready);
        euler_q.insert(euler_q.size(), zyx_angles(x, y, z, w, margin_now));
        if (!quiet && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // margin writes only while nothing is in flight
    task automatic write_margin(input logic [M_W-1:0] m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (euler_q.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        gimbal_margin <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        margin_now = m;
    endtask

    function automatic logic signed [15:0] to_q15(real v);
        real t;
        t = v * 32767.0;
        if (t > 32767.0) t = 32767.0;
        if (t < -32768.0) t = -32768.0;
        return 16'($rtoi(t));
    endfunction

    function automatic real rand_unit();
        return (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
    endfunction

    // well-formed rotation with random orientation
    task automatic send_unit_quat();
        real a[4];
        real n;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            a[i] = rand_unit();
            n += a[i] * a[i];
        end
        if (n < 1.0e-6) begin
            a[3] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        send_quat(to_q15(a[0] / n), to_q15(a[1] / n), to_q15(a[2] / n), to_q15(a[3] / n));
    endtask

    // rotations close to pitch of plus or minus pi/2, where the lock branch lives
    task automatic send_near_lock();
        int d;
        logic signed [15:0] yv;
        logic signed [15:0] wv;
        d = $urandom_range(0, 600);
        yv = 16'(23170 - d);
        wv = 16'(23170 - int'($urandom_range(0, 600)));
        if ($urandom_range(0, 1)) yv = -yv;
        if ($urandom_range(0, 1)) wv = -wv;
        send_quat(16'(int'($urandom_range(0, 800)) - 400), yv,
                  16'(int'($urandom_range(0, 800)) - 400), wv);
    endtask

    task automatic send_raw_quat();
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // extremes of the fields and the named special cases
    task automatic test_directed();
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);              // all zero
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);          // identity
        send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);         // zero numerator, negative den
        send_quat(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);   // non-unit
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd32767);      // asin saturates high
        send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);     // asin saturates low
        send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0);     // pitch +pi/2 via xz
        send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0);      // pitch -pi/2 via xz
        send_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170);      // exact lock, positive
        send_quat(16'sd0, -16'sd23170, 16'sd0, 16'sd23170);     // exact lock, negative
        send_quat(16'sd100, 16'sd23170, -16'sd50, 16'sd23170);
        send_quat(16'sd100, -16'sd23170, 16'sd50, 16'sd23170);
        send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    endtask

    // margin extremes: zero never locks, full width gives the widest lock band
    task automatic test_margin();
        logic [M_W-1:0] settings[3];
        settings = '{12'd0, 12'd4095, 12'(2 + $urandom_range(0, 60))};
        foreach (settings[k]) begin
            write_margin(settings[k]);
            send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd32767);
            send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
            for (int i = 0; i < 25; i++) send_near_lock();
            for (int i = 0; i < 15; i++) send_unit_quat();
        end
    endtask

    // mostly well-formed rotations, some near lock, some raw noise
    task automatic test_random();
        int pick;
        for (int ph = 0; ph < 3; ph++) begin
            write_margin((ph == 1) ? 12'd1 : 12'($urandom_range(0, 300)));
            for (int i = 0; i < 470; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) send_unit_quat();
                else if (pick < 75) send_near_lock();
                else send_raw_quat();
            end
        end
    endtask

    task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %0d, got %0d (cycle %0d)", what, exp_v, got_v, cycle);
    endtask

    // result side: random back-pressure and in-order compare
    always @(posedge clk) begin
        euler_t e;
        cycle <= cycle + 1;
        if (rst_n && out_valid && out_ready) begin
            if (euler_q.size() == 0) begin
                note_mismatch("unexpected item, roll", 0, roll_angle);
            end
            else begin
                e = euler_q.pop_front();
                if (roll_angle !== e.roll) note_mismatch("roll", e.roll, roll_angle);
                if (pitch_angle !== e.pitch) note_mismatch("pitch", e.pitch, pitch_angle);
                if (yaw_angle !== e.yaw) note_mismatch("yaw", e.yaw, yaw_angle);
                if (gimbal_lock !== e.lock) note_mismatch("lock", e.lock, gimbal_lock);
            end
        end
        out_ready <= rst_n && (quiet || $urandom_range(0, 99) >= 6);
    end

    // watchdog
    always @(posedge clk) begin
        if (cycle > LIMIT) begin
            $display("quaternion_to_euler_angles_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_margin();
        test_random();
        in_valid <= 1'b0;
        while (euler_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && euler_q.size() == 0)
            $display("quaternion_to_euler_angles_unit: match");
        else
            $display("quaternion_to_euler_angles_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/q2e_pkg.sv
rtl/q2e_root_cell.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_angles_unit.sv
test/tb_top.sv
